>>> src/mexp_pkg.sv
package mexp_pkg;

    // Width of the data ports and configuration registers.
    localparam int FIELD_W = 32;

    // Operand width of the arithmetic (8 to 32); wider bits of the ports are ignored.
    localparam int OPW = 32;

    // Bit counter of the serial modular multiplier.
    localparam int CNT_W = $clog2(OPW);

    localparam int CFG_IDX_W = 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_EXPONENT = 1'b0;
    localparam t_cfg_idx CFG_MODULUS  = 1'b1;

endpackage

>>> src/mexp_mulmod.sv
module mexp_mulmod import mexp_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [OPW-1:0] i_a,
    input  logic [OPW-1:0] i_b,
    input  logic [OPW:0]   i_mod,
    output logic           o_done,
    output logic [OPW-1:0] o_prod
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [OPW-1:0]   r_a;
    logic [OPW-1:0]   r_b;
    logic [OPW-1:0]   r_r;

    logic [OPW+1:0] w_t;
    logic [OPW+2:0] w_m1;
    logic [OPW+2:0] w_m2;
    logic [OPW-1:0] w_red;

    // One multiplier bit per cycle, MSB first: r = (2r + bit*b) mod M.
    // With r < M and b < M the sum stays below 3M, so pick among t, t-M, t-2M.
    always_comb begin
        w_t  = {1'b0, r_r, 1'b0} + (r_a[OPW-1] ? {2'b00, r_b} : '0);
        w_m1 = {1'b0, w_t} - {2'b00, i_mod};
        w_m2 = {1'b0, w_t} - {1'b0, i_mod, 1'b0};
        if (!w_m2[OPW+2]) begin
            w_red = w_m2[OPW-1:0];
        end else if (!w_m1[OPW+2]) begin
            w_red = w_m1[OPW-1:0];
        end else begin
            w_red = w_t[OPW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(OPW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_r <= '0;
        end else if (r_busy) begin
            r_a <= {r_a[OPW-2:0], 1'b0};
            r_r <= w_red;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_r;

endmodule

>>> src/modular_exponentiation_top.sv
// Modular exponentiation, base^exponent mod modulus, by right-to-left square and
// multiply. Exponent (index 0) and modulus (index 1) are written through the config
// port; the user must write them only while the block is idle, which the block itself
// does not enforce. A modulus of zero acts as 2^32 and an exponent of zero gives 1.
// One item is processed at a time. The base is first reduced by a bit-serial modular
// multiplier; each exponent bit up to the highest set one then takes a step in which
// two such multipliers (square and accumulate) shift one multiplier bit per cycle in
// parallel. After the last step the result goes into the output register once that
// register is free or being read, and only then is the next input taken; a zero
// exponent goes straight to the result. A finished result waits in the output
// register, and the next item may be taken while it waits.
module modular_exponentiation_top import mexp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [FIELD_W-1:0] i_base_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FIELD_W-1:0] o_power_result,
    input  logic               i_cfg_we,
    input  t_cfg_idx           i_cfg_idx,
    input  logic [FIELD_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REDUCE = 4'b0010,
        S_STEP   = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [FIELD_W-1:0] r_exp, n_exp;
    logic [FIELD_W-1:0] r_mod, n_mod;
    logic [OPW-1:0]     r_e, n_e;
    logic [OPW-1:0]     r_sq, n_sq;
    logic [OPW-1:0]     r_acc, n_acc;
    logic               r_kick, n_kick;
    logic               r_out_valid, n_out_valid;
    logic [FIELD_W-1:0] r_out_data, n_out_data;

    logic [OPW-1:0] w_exp;
    logic [OPW:0]   w_mod;
    logic           w_in_xfer;
    logic           w_sq_start;
    logic [OPW-1:0] w_sq_a;
    logic [OPW-1:0] w_sq_b;
    logic           w_sq_done;
    logic [OPW-1:0] w_sq_prod;
    logic           w_acc_done;
    logic [OPW-1:0] w_acc_prod;

    assign w_exp = r_exp[OPW-1:0];
    // A zero modulus stands for 2^OPW.
    assign w_mod = {~|r_mod[OPW-1:0], r_mod[OPW-1:0]};

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    // Squaring unit also reduces the base first, as base * 1 mod M.
    assign w_sq_start = (w_in_xfer && (|w_exp)) || r_kick;
    assign w_sq_a     = (r_state == S_IDLE) ? i_base_value[OPW-1:0] : r_sq;
    assign w_sq_b     = (r_state == S_IDLE) ? OPW'(1) : r_sq;

    mexp_mulmod u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_a     (w_sq_a),
        .i_b     (w_sq_b),
        .i_mod   (w_mod),
        .o_done  (w_sq_done),
        .o_prod  (w_sq_prod)
    );

    mexp_mulmod u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick),
        .i_a     (r_acc),
        .i_b     (r_sq),
        .i_mod   (w_mod),
        .o_done  (w_acc_done),
        .o_prod  (w_acc_prod)
    );

    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_mod       = r_mod;
        n_e         = r_e;
        n_sq        = r_sq;
        n_acc       = r_acc;
        n_kick      = 1'b0;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXPONENT: n_exp = i_cfg_data;
                CFG_MODULUS:  n_mod = i_cfg_data;
                default:      ;
            endcase
        end

        // Drop the result once it has been transferred.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_e     = w_exp;
                    n_acc   = OPW'(1);
                    n_state = (|w_exp) ? S_REDUCE : S_DONE;
                end
            end
            S_REDUCE: begin
                if (w_sq_done) begin
                    n_sq    = w_sq_prod;
                    n_kick  = 1'b1;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (w_sq_done) begin
                    n_sq = w_sq_prod;
                    if (r_e[0]) begin
                        n_acc = w_acc_prod;
                    end
                    n_e = {1'b0, r_e[OPW-1:1]};
                    // Stop after the highest set exponent bit.
                    if (|r_e[OPW-1:1]) begin
                        n_kick = 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = FIELD_W'(r_acc);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exp       <= FIELD_W'(65537);
            r_mod       <= FIELD_W'(1);
            r_kick      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exp       <= n_exp;
            r_mod       <= n_mod;
            r_kick      <= n_kick;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e        <= n_e;
        r_sq       <= n_sq;
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_out_data;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_in_stall)
        else $error("input taken while an item is in progress");

    a_units_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && w_sq_done) |-> w_acc_done)
        else $error("square and accumulate units out of step");

    a_square_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_STEP || r_state == S_REDUCE) && w_sq_done)
            |-> ({1'b0, w_sq_prod} < w_mod))
        else $error("square not reduced below modulus");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result shown without a finished item");

endmodule

>>> sim/tb_modular_exponentiation_top.sv
`timescale 1ns / 100ps

module tb_modular_exponentiation_top;
    import mexp_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE_TICKS = 1200;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic [FIELD_W-1:0] i_base_value   = '0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic [FIELD_W-1:0] o_power_result;
    logic               i_cfg_we       = 1'b0;
    t_cfg_idx           i_cfg_idx      = CFG_EXPONENT;
    logic [FIELD_W-1:0] i_cfg_data     = '0;

    // Key as the block should hold it, tracked beside every register write.
    logic [31:0] key_exponent = 32'd65537;
    logic [31:0] key_modulus  = 32'd1;

    logic [31:0] pending_powers[$];
    logic [31:0] want_power;
    int          fail_count = 0;
    int          cycle_count = 0;

    // Sender burst shaping.
    int burst_left = 0;
    bit no_idle = 1'b0;

    // Receiver stall pattern and long hold-off.
    int hold_request = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int phase_cnt = 0;

    modular_exponentiation_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_base_value   (i_base_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_power_result (o_power_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Right-to-left square and multiply; a zero modulus stands for 2^32.
    function automatic logic [31:0] power_mod(logic [31:0] base);
        logic [63:0] m;
        logic [63:0] acc;
        logic [63:0] sq;
        if (key_exponent == 32'd0)
            return 32'd1;
        m = (key_modulus == 32'd0) ? 64'h1_0000_0000 : {32'd0, key_modulus};
        acc = 64'd1;
        sq = {32'd0, base} % m;
        for (int i = 0; i < 32; i++) begin
            if (key_exponent[i])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
        end
        return acc[31:0];
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_powers.size() == 0) begin
                $error("power_result: expected none, actual %h", o_power_result);
                fail_count++;
            end else begin
                want_power = pending_powers.pop_front();
                if (o_power_result !== want_power) begin
                    $error("power_result: expected %h, actual %h", want_power, o_power_result);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: switch between stall patterns; a hold-off request overrides them.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        phase_cnt++;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 9) < 3);
                2: i_out_stall <= ($urandom_range(0, 9) < 7);
                default: i_out_stall <= ((phase_cnt % 7) < 3);
            endcase
        end
    end

    task automatic send_base(input logic [31:0] base);
        int gap_len;
        if (burst_left == 0) begin
            if (!no_idle) begin
                gap_len = $urandom_range(1, 12);
                i_in_valid <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_base_value <= base;
        do @(posedge i_clk); while (o_in_stall);
        pending_powers.insert(pending_powers.size(), power_mod(base));
    endtask

    task automatic wait_all_powers;
        i_in_valid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge i_clk);
    endtask

    // Write both registers; call only with nothing in flight.
    task automatic set_key(input logic [31:0] exponent_val, input logic [31:0] modulus_val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_EXPONENT;
        i_cfg_data <= exponent_val;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MODULUS;
        i_cfg_data <= modulus_val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        key_exponent = exponent_val;
        key_modulus  = modulus_val;
    endtask

    task automatic test_reset_key;
        send_base(32'hFFFF_FFFF);
        send_base(32'd5);
        wait_all_powers();
    endtask

    task automatic test_exponent_zero;
        set_key(32'd0, 32'd1);
        send_base(32'd0);
        send_base(32'hFFFF_FFFF);
        wait_all_powers();
        set_key(32'd0, 32'd0);
        send_base(32'd7);
        wait_all_powers();
    endtask

    task automatic test_modulus_wrap;
        set_key(32'hFFFF_FFFF, 32'd0);
        send_base(32'd3);
        send_base(32'hFFFF_FFFF);
        send_base(32'h8000_0000);
        wait_all_powers();
        set_key(32'd1, 32'd0);
        send_base(32'hDEAD_BEEF);
        wait_all_powers();
    endtask

    task automatic test_operand_extremes;
        set_key(32'd65537, 32'd3233);
        send_base(32'd0);
        send_base(32'd1);
        send_base(32'd65);
        send_base(32'd3232);
        send_base(32'd3233);
        send_base(32'hFFFF_FFFF);
        wait_all_powers();
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_base(32'hFFFF_FFFE);
        send_base(32'hFFFF_FFFF);
        send_base(32'd2);
        send_base(32'h1234_5678);
        wait_all_powers();
        set_key(32'd1, 32'hFFFF_FFFB);
        send_base(32'hFFFF_FFFF);
        wait_all_powers();
    endtask

    // Hold the receiver off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure;
        set_key(32'd3, $urandom | 32'h8000_0000);
        no_idle = 1'b1;
        hold_request = 800;
        repeat (12) send_base($urandom);
        wait_all_powers();
        no_idle = 1'b0;
    endtask

    task automatic test_random_keys;
        logic [31:0] e;
        logic [31:0] m;
        logic [31:0] b;
        int          n;
        for (int phase = 0; phase < 9; phase++) begin
            case ($urandom_range(0, 4))
                0: e = $urandom;
                1: e = $urandom >> $urandom_range(20, 31);
                2: e = 32'd1 << $urandom_range(0, 31);
                3: e = $urandom_range(0, 2);
                default: e = 32'hFFFF_FFFF >> $urandom_range(0, 31);
            endcase
            case ($urandom_range(0, 5))
                0: m = $urandom;
                1: m = $urandom_range(2, 65535);
                2: m = 32'd0;
                3: m = 32'd1;
                4: m = 32'hFFFF_FFFF - $urandom_range(0, 100);
                default: m = $urandom | 32'h8000_0000;
            endcase
            set_key(e, m);
            no_idle = ($urandom_range(0, 3) == 0);
            n = $urandom_range(22, 32);
            repeat (n) begin
                case ($urandom_range(0, 19))
                    0: b = 32'd0;
                    1: b = 32'd1;
                    2: b = 32'hFFFF_FFFF;
                    3: b = m - 32'd1;
                    4, 5, 6: b = (m != 32'd0) ? ($urandom % m) : $urandom;
                    default: b = $urandom;
                endcase
                send_base(b);
            end
            wait_all_powers();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_key();
        test_exponent_zero();
        test_modulus_wrap();
        test_operand_extremes();
        test_backpressure();
        test_random_keys();
        // Let any stray transfer show up before the verdict.
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fail_count == 0 && pending_powers.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> modular_exponentiation_top.f
src/mexp_pkg.sv
src/mexp_mulmod.sv
src/modular_exponentiation_top.sv
sim/tb_modular_exponentiation_top.sv
